// ===== rtl/core/ohma_pkg.sv =====
// Shared constants for the outlier-hold moving average core.
package ohma_pkg;

    localparam int SAMPLE_W = 16;

    // Number of entries in the averaging window (2 to 64).
    localparam int WINDOW = 30;

    localparam logic [SAMPLE_W-1:0] LIMIT_RESET = 16'd7000;

    // The running sum must hold WINDOW full-scale samples.
    localparam int SUM_W = $clog2(65535 * WINDOW + 1);

    // Constant divide by WINDOW as a multiply by a rounded-up reciprocal and a shift.
    // With the shift at SUM_W plus ceil(log2(WINDOW)) the quotient is exact for every sum.
    localparam int WIN_LOG = $clog2(WINDOW);
    localparam int DIV_SHIFT = SUM_W + WIN_LOG;
    localparam int MULT_W = SUM_W + 1;
    localparam logic [63:0] DIV_MULT = ((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam int PROD_W = SUM_W + MULT_W;

endpackage

// ===== rtl/core/ohma_cell.sv =====
// One window cell: holds a stored sample and passes it on along the chain.
module ohma_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           shift_en,
    input  logic [ohma_pkg::SAMPLE_W-1:0]  data_in,
    output logic [ohma_pkg::SAMPLE_W-1:0]  data_out
);

    logic [ohma_pkg::SAMPLE_W-1:0] value_reg;
    logic [ohma_pkg::SAMPLE_W-1:0] value_next;

    always_comb begin
        value_next = shift_en ? data_in : value_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else begin
            value_reg <= value_next;
        end
    end

    assign data_out = value_reg;

endmodule

// ===== rtl/core/ohma_div.sv =====
// Constant divider stage: multiplies the window sum by the reciprocal and registers it.
module ohma_div (
    input  logic                           aclk,
    input  logic                           load,
    input  logic [ohma_pkg::SUM_W-1:0]     sum_in,
    input  logic                           rejected_in,
    output logic [ohma_pkg::SAMPLE_W-1:0]  average_out,
    output logic                           rejected_out
);

    localparam logic [ohma_pkg::MULT_W-1:0] MULT = ohma_pkg::MULT_W'(ohma_pkg::DIV_MULT);

    logic [ohma_pkg::PROD_W-1:0] prod_reg;
    logic [ohma_pkg::PROD_W-1:0] prod_next;
    logic                        rejected_reg;
    logic                        rejected_next;

    always_comb begin
        prod_next     = prod_reg;
        rejected_next = rejected_reg;
        if (load) begin
            prod_next     = ohma_pkg::PROD_W'(sum_in) * ohma_pkg::PROD_W'(MULT);
            rejected_next = rejected_in;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= prod_next;
        rejected_reg <= rejected_next;
    end

    assign average_out  = prod_reg[ohma_pkg::DIV_SHIFT +: ohma_pkg::SAMPLE_W];
    assign rejected_out = rejected_reg;

endmodule

// ===== rtl/core/outlier_hold_moving_average_core.sv =====
// Top level of the outlier-hold moving average: cell chain, running sum and divider.
//
//  Channel   Ports                                        Direction
//  input     s_valid s_ready s_distance_sample            in
//  result    m_valid m_ready m_average_distance           out
//            m_sample_rejected
//  config    cfg_valid cfg_ready cfg_data                 in
//
// One item is accepted per cycle while s_ready is high; its sum is registered first, and
// the divider then registers the result and raises m_valid once the result stage is free.
// The window is a chain of WINDOW cells that shifts once per item, so the oldest entry
// leaves from the far end while the running sum is updated in the same cycle.
// Reset clears the cells, the sum and the limit (to 7000) at once; no clearing pass.
// A waiting result lets one more item into the sum stage; the input then stalls until
// the result is taken.
module outlier_hold_moving_average_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ohma_pkg::SAMPLE_W-1:0]  s_distance_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ohma_pkg::SAMPLE_W-1:0]  m_average_distance,
    output logic                           m_sample_rejected,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ohma_pkg::SAMPLE_W-1:0]  cfg_data
);

    logic [ohma_pkg::SAMPLE_W-1:0] limit_reg;
    logic [ohma_pkg::SAMPLE_W-1:0] limit_next;
    logic [ohma_pkg::SUM_W-1:0]    sum_reg;
    logic [ohma_pkg::SUM_W-1:0]    sum_next;
    logic                          sum_valid_reg;
    logic                          sum_valid_next;
    logic                          rejected_reg;
    logic                          rejected_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;

    logic                          accept;
    logic                          out_load;
    logic                          rejected;
    logic [ohma_pkg::SAMPLE_W-1:0] entry;
    logic [ohma_pkg::SAMPLE_W-1:0] chain [ohma_pkg::WINDOW];

    // The newest entry sits in the first cell, the oldest in the last.
    genvar i;
    generate
        for (i = 0; i < ohma_pkg::WINDOW; i++) begin : g_cell
            if (i == 0) begin : g_head
                ohma_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (accept),
                    .data_in  (entry),
                    .data_out (chain[i])
                );
            end else begin : g_body
                ohma_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (accept),
                    .data_in  (chain[i-1]),
                    .data_out (chain[i])
                );
            end
        end
    endgenerate

    assign out_load  = sum_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !sum_valid_reg || out_load;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // A rejected sample repeats the value most recently stored, held in the first cell.
    assign rejected = s_distance_sample > limit_reg;
    assign entry    = rejected ? chain[0] : s_distance_sample;

    always_comb begin
        limit_next     = limit_reg;
        sum_next       = sum_reg;
        sum_valid_next = sum_valid_reg;
        rejected_next  = rejected_reg;
        m_valid_next   = m_valid_reg;

        if (cfg_valid && cfg_ready) begin
            limit_next = cfg_data;
        end

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            sum_next       = sum_reg - ohma_pkg::SUM_W'(chain[ohma_pkg::WINDOW-1])
                             + ohma_pkg::SUM_W'(entry);
            rejected_next  = rejected;
            sum_valid_next = 1'b1;
        end else if (out_load) begin
            sum_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= ohma_pkg::LIMIT_RESET;
            sum_reg       <= '0;
            sum_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            limit_reg     <= limit_next;
            sum_reg       <= sum_next;
            sum_valid_reg <= sum_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rejected_reg <= rejected_next;
    end

    ohma_div u_div (
        .aclk         (aclk),
        .load         (out_load),
        .sum_in       (sum_reg),
        .rejected_in  (rejected_reg),
        .average_out  (m_average_distance),
        .rejected_out (m_sample_rejected)
    );

    assign m_valid = m_valid_reg;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the outlier-hold moving average core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Tracks the window and the outlier limit, and queues the mean expected for each item.
    class average_tracker;
        typedef struct packed {
            logic [ohma_pkg::SAMPLE_W-1:0] average;
            logic                          rejected;
        } window_mean_t;

        logic [ohma_pkg::SAMPLE_W-1:0] limit;
        logic [ohma_pkg::SAMPLE_W-1:0] ring [ohma_pkg::WINDOW];
        int unsigned                   slot;
        logic [ohma_pkg::SUM_W-1:0]    total;
        logic [ohma_pkg::SAMPLE_W-1:0] last_entry;
        window_mean_t                  pending_means[$];
        int                            errors;
        int                            samples_seen;
        int                            rejects_seen;

        function new();
            limit = ohma_pkg::LIMIT_RESET;
            foreach (ring[k]) ring[k] = '0;
            slot = 0;
            total = '0;
            last_entry = '0;
            errors = 0;
            samples_seen = 0;
            rejects_seen = 0;
        endfunction

        function void set_limit(input logic [ohma_pkg::SAMPLE_W-1:0] value);
            limit = value;
        endfunction

        function void note_sample(input logic [ohma_pkg::SAMPLE_W-1:0] sample);
            window_mean_t                  mean;
            logic [ohma_pkg::SAMPLE_W-1:0] entry;
            mean.rejected = sample > limit;
            // A rejected sample repeats the last stored value at the current slot.
            entry = mean.rejected ? last_entry : sample;
            total = total - ring[slot] + entry;
            ring[slot] = entry;
            last_entry = entry;
            slot = (slot == ohma_pkg::WINDOW - 1) ? 0 : slot + 1;
            mean.average = 16'(total / ohma_pkg::WINDOW);
            pending_means.push_back(mean);
            samples_seen++;
            if (mean.rejected) rejects_seen++;
        endfunction

        function void check_mean(input logic [ohma_pkg::SAMPLE_W-1:0] average,
                                 input logic rejected);
            window_mean_t want;
            if (pending_means.size() == 0) begin
                $error("result with no item outstanding: average_distance %0d", average);
                errors++;
                return;
            end
            want = pending_means.pop_front();
            if (average !== want.average) begin
                $error("average_distance: expected %0d, got %0d", want.average, average);
                errors++;
            end
            if (rejected !== want.rejected) begin
                $error("sample_rejected: expected %0b, got %0b", want.rejected, rejected);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_means.size();
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [ohma_pkg::SAMPLE_W-1:0] s_distance_sample;
    logic                          m_valid;
    logic                          m_ready;
    logic [ohma_pkg::SAMPLE_W-1:0] m_average_distance;
    logic                          m_sample_rejected;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [ohma_pkg::SAMPLE_W-1:0] cfg_data;

    average_tracker                tracker = new();
    int                            tx_idle_pct;
    int                            rx_idle_pct;
    int                            hold_len;
    int                            hold_seq;
    logic [ohma_pkg::SAMPLE_W-1:0] cur_limit;
    int                            limit_writes;

    outlier_hold_moving_average_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_distance_sample  (s_distance_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_average_distance (m_average_distance),
        .m_sample_rejected  (m_sample_rejected),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // All handshakes are observed here, so the order within one edge is fixed.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) tracker.set_limit(cfg_data);
            if (s_valid && s_ready) tracker.note_sample(s_distance_sample);
            if (m_valid && m_ready) tracker.check_mean(m_average_distance, m_sample_rejected);
        end
    end

    // Result side: random back-pressure, plus a long hold-off when one is requested.
    initial begin
        int hold_left;
        int hold_seen;
        m_ready = 1'b0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_sample(input logic [ohma_pkg::SAMPLE_W-1:0] sample);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_distance_sample <= sample;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Waits until every result is back, then lets the pipeline settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [ohma_pkg::SAMPLE_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_limit = value;
        limit_writes++;
    endtask

    function automatic logic [ohma_pkg::SAMPLE_W-1:0] pick_limit();
        case ($urandom_range(4))
            0: return 16'($urandom_range(65535));
            1: return 16'($urandom_range(12000, 100));
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return ohma_pkg::LIMIT_RESET;
        endcase
    endfunction

    // Half the draws sit at or below the limit, a quarter above it (at it for FFFF), a quarter anywhere.
    function automatic logic [ohma_pkg::SAMPLE_W-1:0] make_sample(
        input logic [ohma_pkg::SAMPLE_W-1:0] lim);
        case ($urandom_range(7))
            0, 1: return 16'($urandom_range(65535));
            2, 3, 4: return 16'($urandom_range(lim));
            5: return lim;
            default: return (lim == 16'hFFFF) ? lim : 16'($urandom_range(65535, lim + 1));
        endcase
    endfunction

    initial begin
        logic [ohma_pkg::SAMPLE_W-1:0] first_batch[$];
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_distance_sample = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_len = 0;
        hold_seq = 0;
        cur_limit = ohma_pkg::LIMIT_RESET;
        limit_writes = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset limit: an outlier before anything was stored holds zero, then the boundary.
        first_batch = {16'd7001, 16'd65535, 16'd7000, 16'd0, 16'd6999, 16'd1,
                       16'd7000, 16'd65535, 16'h5555, 16'h2AAA};
        foreach (first_batch[k]) send_sample(first_batch[k]);

        // Top limit: nothing can be rejected.
        write_limit(16'hFFFF);
        first_batch = {16'hFFFF, 16'hFFFE, 16'h8000, 16'hFFFF, 16'h7FFF};
        foreach (first_batch[k]) send_sample(first_batch[k]);

        // Zero limit: everything but zero is replaced.
        write_limit(16'h0000);
        first_batch = {16'd0, 16'd1, 16'hFFFF, 16'd0, 16'h8000};
        foreach (first_batch[k]) send_sample(first_batch[k]);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 26;
                    rx_idle_pct = 66;
                end
                1: begin
                    tx_idle_pct = 66;
                    rx_idle_pct = 26;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 3; blk++) begin
                write_limit(pick_limit());
                // With the sender flooding, a long hold on the result side backs the core up.
                if (phase == 2 && blk == 0) begin
                    hold_len = 250;
                    hold_seq++;
                end
                for (int n = 0; n < 150; n++) send_sample(make_sample(cur_limit));
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (tracker.outstanding() != 0) begin
            $error("%0d results never arrived", tracker.outstanding());
            tracker.errors++;
        end
        $display("Run covered %0d samples, %0d of them rejected, over %0d limit writes,",
                 tracker.samples_seen, tracker.rejects_seen, limit_writes);
        $display("with random stalls on both sides and one long hold on the result side.");
        if (tracker.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/ohma_pkg.sv
rtl/core/ohma_cell.sv
rtl/core/ohma_div.sv
rtl/core/outlier_hold_moving_average_core.sv
tb/tb.sv
